// ===== src/rgbhsv_pkg.sv =====
// Shared types, constants and the divider step function for the RGB to HSV converter.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package rgbhsv_pkg;

   // Field widths.
   localparam int CH_W  = 8;
   localparam int HUE_W = 15;
   localparam int SAT_W = 16;

   // Hue is reported in units of 1/2^HUE_FRACTION_BITS degree.
   localparam int HUE_FRACTION_BITS = 6;

   // Hue geometry in degrees.
   localparam int HUE_SIXTY  = 60;
   localparam int HUE_GREEN  = 120;
   localparam int HUE_BLUE   = 240;
   localparam int HUE_CIRCLE = 360;
   localparam int CH_MAX     = (1 << CH_W) - 1;

   localparam int FULL_TURN = HUE_CIRCLE << HUE_FRACTION_BITS;

   // Hue numerator (base * chroma +/- 60 * difference) and its 60 * difference term.
   localparam int NUM_W   = $clog2(HUE_CIRCLE * CH_MAX + 1);
   localparam int MAG60_W = $clog2(HUE_SIXTY * CH_MAX + 1);

   // Divider geometry. Both quotients fit QUOT_W bits, so the top CH_W bits of a
   // dividend are always below the divisor and seed the partial remainder.
   localparam int STEPS_PER_STAGE = 4;
   localparam int HUE_Q_W         = $clog2(FULL_TURN + 1);
   localparam int QUOT_MIN_W      = (HUE_Q_W > SAT_W) ? HUE_Q_W : SAT_W;
   localparam int QUOT_W          = ((QUOT_MIN_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE)
                                    * STEPS_PER_STAGE;
   localparam int DIV_STAGES      = QUOT_W / STEPS_PER_STAGE;
   localparam int DIVIDEND_W      = QUOT_W + CH_W;
   localparam int REM_W           = CH_W + 1;

   // Divider lanes.
   localparam int LANES    = 2;
   localparam int LANE_SAT = 0;
   localparam int LANE_HUE = 1;

   // Edges from the accepting edge to the edge that takes the result.
   localparam int PIPE_LATENCY = 4 + DIV_STAGES;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      logic [DIVIDEND_W-1:0] dividend;
      logic [CH_W-1:0]       divisor;
   } div_lane_type;

   typedef struct packed {
      logic [CH_W-1:0]   rem;
      logic [QUOT_W-1:0] work;
      logic [CH_W-1:0]   divisor;
   } div_state_type;

   // Several restoring division steps: each shifts one dividend bit into the
   // remainder and one quotient bit into the low end of the work word.
   function automatic div_state_type div_steps(input div_state_type s);
      div_state_type    t;
      logic [REM_W-1:0] part;
      logic [REM_W-1:0] diff;
      t = s;
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
         part   = {t.rem, t.work[QUOT_W-1]};
         diff   = part - {1'b0, t.divisor};
         t.work = {t.work[QUOT_W-2:0], 1'b0};
         if (part >= {1'b0, t.divisor}) begin
            t.rem     = diff[CH_W-1:0];
            t.work[0] = 1'b1;
         end else begin
            t.rem = part[CH_W-1:0];
         end
      end
      return t;
   endfunction

endpackage

// ===== src/rgbhsv_div.sv =====
// Pipelined restoring divider with parallel lanes sharing one valid chain.
// Depends on rgbhsv_pkg for widths, lane types and the step function.
`timescale 1ns / 1ps

module rgbhsv_div (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  in_valid,
   input  rgbhsv_pkg::div_lane_type [rgbhsv_pkg::LANES-1:0]      in_lane,
   output logic                                                  out_valid,
   output logic [rgbhsv_pkg::LANES-1:0][rgbhsv_pkg::QUOT_W-1:0]  out_quot
);
   import rgbhsv_pkg::*;

   div_state_type          stage_ff [DIV_STAGES][LANES];
   div_state_type          stage_in [DIV_STAGES][LANES];
   logic [DIV_STAGES-1:0]  valid_ff;
   logic [DIV_STAGES-1:0]  valid_in;

   always_comb begin
      div_state_type load;
      load = '0;
      for (int l = 0; l < LANES; l++) begin
         load.rem     = in_lane[l].dividend[DIVIDEND_W-1 -: CH_W];
         load.work    = in_lane[l].dividend[QUOT_W-1:0];
         load.divisor = in_lane[l].divisor;
         stage_in[0][l] = div_steps(load);
         for (int s = 1; s < DIV_STAGES; s++) begin
            stage_in[s][l] = div_steps(stage_ff[s-1][l]);
         end
      end
   end

   always_comb begin
      valid_in[0] = in_valid;
      for (int s = 1; s < DIV_STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff[DIV_STAGES-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quot[l] = stage_ff[DIV_STAGES-1][l].work;
      end
   end

endmodule

// ===== src/rgb_to_hsv_converter_top.sv =====
// RGB to HSV converter: a pixel passes stages 1 to 3, the divider stages and the output
// register in order; throughput one pixel per clock while busy is low.
// The receiver cannot stall; busy is low except while reset is held and the first cycle after it.
// Reset is synchronous and active high; it clears all valid bits, so in-flight pixels
// are dropped, and busy stays high for the first cycle after reset.
// Depends on rgbhsv_pkg and the pipelined divider rgbhsv_div.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [rgbhsv_pkg::CH_W-1:0]    req_red,
   input  logic [rgbhsv_pkg::CH_W-1:0]    req_green,
   input  logic [rgbhsv_pkg::CH_W-1:0]    req_blue,
   input  logic [rgbhsv_pkg::CH_W-1:0]    req_opacity,
   output logic                           rsp_valid,
   output logic [rgbhsv_pkg::HUE_W-1:0]   rsp_hue,
   output logic [rgbhsv_pkg::SAT_W-1:0]   rsp_saturation,
   output logic [rgbhsv_pkg::CH_W-1:0]    rsp_brightness,
   output logic [rgbhsv_pkg::CH_W-1:0]    rsp_opacity_out,
   output logic                           rsp_is_grey
);
   import rgbhsv_pkg::*;

   // Pixel data that rides alongside the divider.
   typedef struct packed {
      logic [CH_W-1:0] brightness;
      logic [CH_W-1:0] opacity;
      logic            grey;
   } side_type;

   logic accept;

   // The pipeline never stalls, so busy only covers reset and the cycle right after it.
   logic busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // ---------------------------------------------------------------------------------
   // Stage 1: find the largest and smallest channel and pick the hue sector. The tie
   // rule makes red win over green and green over blue. The signed channel difference
   // of the sector is kept as a magnitude and a sign.
   // ---------------------------------------------------------------------------------
   logic            s1_valid_ff;
   logic [CH_W-1:0] s1_max_ff, s1_max_in;
   logic [CH_W-1:0] s1_min_ff, s1_min_in;
   sector_type      s1_sector_ff, s1_sector_in;
   logic            s1_neg_ff, s1_neg_in;
   logic [CH_W-1:0] s1_mag_ff, s1_mag_in;
   logic [CH_W-1:0] s1_opacity_ff;

   always_comb begin
      logic            red_top;
      logic            green_top;
      logic [CH_W-1:0] minuend;
      logic [CH_W-1:0] subtrahend;
      red_top   = (req_red >= req_green) && (req_red >= req_blue);
      green_top = !red_top && (req_green >= req_blue);
      if (red_top) begin
         s1_max_in    = req_red;
         s1_sector_in = SECTOR_RED;
         minuend      = req_green;
         subtrahend   = req_blue;
      end else if (green_top) begin
         s1_max_in    = req_green;
         s1_sector_in = SECTOR_GREEN;
         minuend      = req_blue;
         subtrahend   = req_red;
      end else begin
         s1_max_in    = req_blue;
         s1_sector_in = SECTOR_BLUE;
         minuend      = req_red;
         subtrahend   = req_green;
      end
      if ((req_red <= req_green) && (req_red <= req_blue)) begin
         s1_min_in = req_red;
      end else if (req_green <= req_blue) begin
         s1_min_in = req_green;
      end else begin
         s1_min_in = req_blue;
      end
      s1_neg_in = minuend < subtrahend;
      s1_mag_in = s1_neg_in ? (subtrahend - minuend) : (minuend - subtrahend);
   end

   // ---------------------------------------------------------------------------------
   // Stage 2: chroma, the 60-degree difference term and the grey flag.
   // ---------------------------------------------------------------------------------
   logic               s2_valid_ff;
   logic [CH_W-1:0]    s2_chroma_ff, s2_chroma_in;
   logic [MAG60_W-1:0] s2_mag60_ff, s2_mag60_in;
   sector_type         s2_sector_ff;
   logic               s2_neg_ff;
   side_type           s2_side_ff, s2_side_in;

   always_comb begin
      s2_chroma_in          = s1_max_ff - s1_min_ff;
      s2_mag60_in           = MAG60_W'(s1_mag_ff) * MAG60_W'(HUE_SIXTY);
      s2_side_in.brightness = s1_max_ff;
      s2_side_in.opacity    = s1_opacity_ff;
      s2_side_in.grey       = (s2_chroma_in == '0);
   end

   // ---------------------------------------------------------------------------------
   // Stage 3: build both dividends. Saturation divides chroma * 65535 + max / 2 by the
   // maximum. Hue divides N * 2^F + floor(chroma / 2) by chroma, the same as rounding
   // N * 2^F / chroma half up, where N = base * chroma +/- 60 * difference. A red
   // maximum with a negative difference uses the 360-degree base, which wraps the hue.
   // ---------------------------------------------------------------------------------
   logic                     s3_valid_ff;
   div_lane_type [LANES-1:0] s3_lane_ff, s3_lane_in;
   side_type                 s3_side_ff;

   always_comb begin
      logic [NUM_W-1:0]      base_term;
      logic [NUM_W-1:0]      num;
      logic [DIVIDEND_W-1:0] chroma_wide;
      chroma_wide = DIVIDEND_W'(s2_chroma_ff);
      unique case (s2_sector_ff)
         SECTOR_RED: begin
            base_term = s2_neg_ff ? NUM_W'(s2_chroma_ff) * NUM_W'(HUE_CIRCLE) : '0;
         end
         SECTOR_GREEN: begin
            base_term = NUM_W'(s2_chroma_ff) * NUM_W'(HUE_GREEN);
         end
         SECTOR_BLUE: begin
            base_term = NUM_W'(s2_chroma_ff) * NUM_W'(HUE_BLUE);
         end
         default: begin
            base_term = '0;
         end
      endcase
      num = s2_neg_ff ? (base_term - NUM_W'(s2_mag60_ff))
                      : (base_term + NUM_W'(s2_mag60_ff));
      s3_lane_in[LANE_HUE].dividend = (DIVIDEND_W'(num) << HUE_FRACTION_BITS)
                                      + DIVIDEND_W'(s2_chroma_ff >> 1);
      s3_lane_in[LANE_HUE].divisor  = s2_chroma_ff;
      s3_lane_in[LANE_SAT].dividend = (chroma_wide << SAT_W) - chroma_wide
                                      + DIVIDEND_W'(s2_side_ff.brightness >> 1);
      s3_lane_in[LANE_SAT].divisor  = s2_side_ff.brightness;
   end

   // Stage registers. Only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_max_ff     <= s1_max_in;
      s1_min_ff     <= s1_min_in;
      s1_sector_ff  <= s1_sector_in;
      s1_neg_ff     <= s1_neg_in;
      s1_mag_ff     <= s1_mag_in;
      s1_opacity_ff <= req_opacity;
      s2_chroma_ff  <= s2_chroma_in;
      s2_mag60_ff   <= s2_mag60_in;
      s2_sector_ff  <= s1_sector_ff;
      s2_neg_ff     <= s1_neg_ff;
      s2_side_ff    <= s2_side_in;
      s3_lane_ff    <= s3_lane_in;
      s3_side_ff    <= s2_side_ff;
   end

   // ---------------------------------------------------------------------------------
   // Divider: both quotients are computed side by side, a few bits per stage. The
   // pixel's side data is delayed by a matching shift line.
   // ---------------------------------------------------------------------------------
   logic                          div_valid;
   logic [LANES-1:0][QUOT_W-1:0]  div_quot;
   side_type                      side_ff [DIV_STAGES];

   rgbhsv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_lane   (s3_lane_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      side_ff[0] <= s3_side_ff;
      for (int s = 1; s < DIV_STAGES; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   // ---------------------------------------------------------------------------------
   // Output stage: a rounded hue of a full circle wraps to zero, grey pixels report
   // hue zero, and a black pixel reports saturation zero. Each result is shown for
   // exactly one cycle under rsp_valid.
   // ---------------------------------------------------------------------------------
   logic             rsp_valid_ff;
   logic [HUE_W-1:0] rsp_hue_ff, rsp_hue_in;
   logic [SAT_W-1:0] rsp_saturation_ff, rsp_saturation_in;
   logic [CH_W-1:0]  rsp_brightness_ff;
   logic [CH_W-1:0]  rsp_opacity_out_ff;
   logic             rsp_is_grey_ff;
   side_type         side_last;

   assign side_last = side_ff[DIV_STAGES-1];

   always_comb begin
      logic [QUOT_W-1:0] hue_wrapped;
      hue_wrapped = (div_quot[LANE_HUE] >= QUOT_W'(FULL_TURN)) ? '0 : div_quot[LANE_HUE];
      rsp_hue_in  = side_last.grey ? '0 : hue_wrapped[HUE_W-1:0];
      rsp_saturation_in = (side_last.brightness == '0) ? '0
                                                       : div_quot[LANE_SAT][SAT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hue_ff         <= rsp_hue_in;
      rsp_saturation_ff  <= rsp_saturation_in;
      rsp_brightness_ff  <= side_last.brightness;
      rsp_opacity_out_ff <= side_last.opacity;
      rsp_is_grey_ff     <= side_last.grey;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hue         = rsp_hue_ff;
   assign rsp_saturation  = rsp_saturation_ff;
   assign rsp_brightness  = rsp_brightness_ff;
   assign rsp_opacity_out = rsp_opacity_out_ff;
   assign rsp_is_grey     = rsp_is_grey_ff;

`ifndef SYNTH
   // Every accepted pixel gives exactly one result after the fixed latency.
   a_result_follows_transfer: assert property (
      @(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LATENCY rsp_valid
   ) else $error("accepted pixel produced no result");

   // No result without a matching transfer.
   a_no_spurious_result: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_LATENCY)
   ) else $error("result without a matching transfer");

   // A grey pixel has zero chroma, so the reported saturation must be zero.
   a_grey_has_no_saturation: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_grey) |-> (rsp_saturation == '0)
   ) else $error("grey pixel with nonzero saturation");

   // A black pixel is grey and unsaturated.
   a_black_is_grey: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_brightness == '0)) |-> (rsp_is_grey && (rsp_saturation == '0))
   ) else $error("black pixel not reported as grey");
`endif

endmodule
